/* rtl/core/three_phase_spwm_third_harmonic_assert.svh */
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef THREE_PHASE_SPWM_THIRD_HARMONIC_ASSERT_SVH
`define THREE_PHASE_SPWM_THIRD_HARMONIC_ASSERT_SVH

// cons must hold in the same cycle as en
`define TPSH_ASSERT_SAME(label, en, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cons)) \
        else $error("tpsh assertion failed");

// cons must hold in the cycle after en
`define TPSH_ASSERT_NEXT(label, en, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cons)) \
        else $error("tpsh assertion failed");

`endif

/* rtl/core/tpsh_pkg.sv */
package tpsh_pkg;

    localparam int unsigned STEPS_PER_TURN = 360;
    localparam int unsigned ANGLE_W        = $clog2(STEPS_PER_TURN);
    localparam int unsigned CMP_W          = 16;
    localparam int unsigned SINE_W         = 16;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned REG_IDX_W      = 2;

    localparam logic [CFG_W-1:0] CARRIER_PEAK_RST  = 16'd4665;
    localparam logic [CFG_W-1:0] MOD_INDEX_RST     = 16'd52429;
    localparam logic [CFG_W-1:0] HARMONIC_GAIN_RST = 16'd10919;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CARRIER_PEAK  = 2'd0,
        REG_MOD_INDEX     = 2'd1,
        REG_HARMONIC_GAIN = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_RD_H,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_WAIT,
        ST_DONE
    } state_t;

    // which sine sample a memory read returns
    typedef enum logic [1:0] {
        SEL_H,
        SEL_A,
        SEL_B,
        SEL_C
    } sel_t;

    typedef struct packed {
        logic valid;
        sel_t sel;
    } tag_t;

    typedef struct packed {
        logic [CFG_W-1:0] carrier_peak;
        logic [CFG_W-1:0] mod_index;
        logic [CFG_W-1:0] harmonic_gain;
    } cfg_t;

    typedef logic [SINE_W-1:0] sine_tab_t [STEPS_PER_TURN];

    // Q1.15 sine of step k, quarter-wave polynomial
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
        longint unsigned u;
        longint unsigned q;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned inner;
        longint unsigned mid;
        longint unsigned r;
        u = (longint'(k) % STEPS_PER_TURN) * 4;
        q = u / STEPS_PER_TURN;
        z = ((u % STEPS_PER_TURN) * 65536) / STEPS_PER_TURN;
        if (q[0])
        begin
            z = 65536 - z;
        end
        z2 = (z * z) >> 16;
        inner = 42048 - ((z2 * 4640) >> 16);
        mid = 102944 - ((z2 * inner) >> 16);
        r = (((z * mid) >> 16) + 1) >> 1;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (q[1])
        begin
            r = 0 - r;
        end
        return r[SINE_W-1:0];
    endfunction

    function automatic sine_tab_t build_sine_table();
        sine_tab_t t;
        for (int i = 0; i < STEPS_PER_TURN; i++)
        begin
            t[i] = sine_entry(i);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

/* rtl/core/tpsh_ram.sv */
module tpsh_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 360
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/tpsh_calc.sv */
module tpsh_calc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tpsh_pkg::tag_t                    rd_tag,
    input  logic [tpsh_pkg::SINE_W-1:0]       rd_data,
    input  tpsh_pkg::cfg_t                    cfg,
    output tpsh_pkg::tag_t                    res_tag,
    output logic [tpsh_pkg::CMP_W-1:0]        res_value
);

    localparam logic [33:0] SUM_BIAS = 34'h0_8000_0000;

    tpsh_pkg::tag_t s1_tag_reg;
    tpsh_pkg::tag_t s2_tag_reg;
    tpsh_pkg::tag_t s3_tag_reg;
    tpsh_pkg::tag_t res_tag_reg;

    logic signed [32:0] fund_next;
    logic signed [32:0] harm_next;
    logic signed [32:0] fund_prod_reg;
    logic signed [32:0] harm_prod_reg;
    logic [33:0]        sum_next;
    logic [33:0]        sum_reg;
    logic [47:0]        peak_prod_next;
    logic [47:0]        peak_prod_reg;
    logic               neg_reg;
    logic               over_reg;
    logic [tpsh_pkg::CMP_W-1:0] value_next;
    logic [tpsh_pkg::CMP_W-1:0] value_reg;

    assign fund_next = 33'($signed({1'b0, cfg.mod_index})) * 33'($signed(rd_data));
    assign harm_next = 33'($signed({1'b0, cfg.harmonic_gain})) * 33'($signed(rd_data));
    assign sum_next = SUM_BIAS + {fund_prod_reg[32], fund_prod_reg}
                    + {harm_prod_reg[32], harm_prod_reg};
    assign peak_prod_next = 48'(cfg.carrier_peak) * 48'(sum_reg[31:0]);

    always_comb
    begin
        priority if (neg_reg)
        begin
            value_next = '0;
        end
        else if (over_reg)
        begin
            value_next = cfg.carrier_peak;
        end
        else
        begin
            value_next = peak_prod_reg[47:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg  <= '0;
            s2_tag_reg  <= '0;
            s3_tag_reg  <= '0;
            res_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg  <= rd_tag;
            s2_tag_reg  <= s1_tag_reg;
            s3_tag_reg  <= s2_tag_reg;
            res_tag_reg <= s3_tag_reg;
        end
    end

    // third harmonic term is held for all three phases
    always_ff @(posedge clk)
    begin
        if (rd_tag.valid && rd_tag.sel == tpsh_pkg::SEL_H)
        begin
            harm_prod_reg <= harm_next;
        end
        fund_prod_reg <= fund_next;
        sum_reg       <= sum_next;
        peak_prod_reg <= peak_prod_next;
        neg_reg       <= sum_reg[33];
        over_reg      <= !sum_reg[33] && sum_reg[32];
        value_reg     <= value_next;
    end

    assign res_tag   = res_tag_reg;
    assign res_value = value_reg;

endmodule

/* rtl/core/three_phase_spwm_third_harmonic.sv */
// Three-phase sine PWM compare generator with third-harmonic injection. Each request on
// s_tdata optionally steps the phase-a angle by one degree (wrapping at 360) and yields one
// result with the compare values for phase a, a+120 and a+240 degrees, each limited to
// 0..carrier_peak, plus the angle used. The sine table lives in a 360-entry memory that is
// loaded from a constant table after reset: while it is filled after rst_n rises, no request is
// taken (configuration writes are). The four sine samples of an item are read through the
// memory's single read port one per cycle and flow through a four-stage multiply pipeline,
// so a new request is taken only after the previous item is loaded into the output register;
// a result waiting in the output register does not block the next request.
`include "three_phase_spwm_third_harmonic_assert.svh"

module three_phase_spwm_third_harmonic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,    // advance
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,    // compare_a, compare_b, compare_c, angle_deg
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpsh_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [tpsh_pkg::CFG_W-1:0]         cfg_data
);

    localparam int unsigned STEPS = tpsh_pkg::STEPS_PER_TURN;
    localparam int unsigned AW    = tpsh_pkg::ANGLE_W;
    localparam logic [AW+1:0] S_EXT   = (AW+2)'(STEPS);
    localparam logic [AW+1:0] S2_EXT  = (AW+2)'(2 * STEPS);
    localparam logic [AW+1:0] OFF_B   = (AW+2)'(STEPS / 3);
    localparam logic [AW+1:0] OFF_C   = (AW+2)'((2 * STEPS) / 3);
    localparam logic [AW-1:0] LAST    = AW'(STEPS - 1);

    tpsh_pkg::state_t state_reg;
    tpsh_pkg::state_t state_next;
    tpsh_pkg::cfg_t   cfg_reg;
    tpsh_pkg::tag_t   issue;
    tpsh_pkg::tag_t   rd_tag_reg;
    tpsh_pkg::tag_t   res_tag;

    logic [AW-1:0] fill_cnt_reg;
    logic [AW-1:0] angle_reg;
    logic [AW-1:0] angle_next;
    logic [AW-1:0] rd_addr;
    logic [AW+1:0] angle_ext;
    logic [AW+1:0] addr_b;
    logic [AW+1:0] addr_c;
    logic [AW+1:0] addr_h;
    logic [AW+1:0] triple;
    logic          wr_en;
    logic          accept;
    logic          out_load;
    logic          out_valid_reg;
    logic [tpsh_pkg::SINE_W-1:0] rd_data;
    logic [tpsh_pkg::CMP_W-1:0]  res_value;
    logic [tpsh_pkg::CMP_W-1:0]  cmp_a_reg;
    logic [tpsh_pkg::CMP_W-1:0]  cmp_b_reg;
    logic [tpsh_pkg::CMP_W-1:0]  cmp_c_reg;
    logic [tpsh_pkg::CMP_W-1:0]  out_a_reg;
    logic [tpsh_pkg::CMP_W-1:0]  out_b_reg;
    logic [tpsh_pkg::CMP_W-1:0]  out_c_reg;
    logic [AW-1:0]               out_angle_reg;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign wr_en     = (state_reg == tpsh_pkg::ST_FILL);
    assign out_load  = (state_reg == tpsh_pkg::ST_DONE) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_peak  <= tpsh_pkg::CARRIER_PEAK_RST;
            cfg_reg.mod_index     <= tpsh_pkg::MOD_INDEX_RST;
            cfg_reg.harmonic_gain <= tpsh_pkg::HARMONIC_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tpsh_pkg::reg_idx_t'(cfg_index))
                tpsh_pkg::REG_CARRIER_PEAK:  cfg_reg.carrier_peak  <= cfg_data;
                tpsh_pkg::REG_MOD_INDEX:     cfg_reg.mod_index     <= cfg_data;
                tpsh_pkg::REG_HARMONIC_GAIN: cfg_reg.harmonic_gain <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // sample addresses, wrapped into 0..STEPS-1
    assign angle_ext = (AW+2)'(angle_reg);
    assign triple    = angle_ext + {angle_ext[AW:0], 1'b0};

    always_comb
    begin
        addr_b = angle_ext + OFF_B;
        if (addr_b >= S_EXT)
        begin
            addr_b = addr_b - S_EXT;
        end
        addr_c = angle_ext + OFF_C;
        if (addr_c >= S_EXT)
        begin
            addr_c = addr_c - S_EXT;
        end
        priority if (triple >= S2_EXT)
        begin
            addr_h = triple - S2_EXT;
        end
        else if (triple >= S_EXT)
        begin
            addr_h = triple - S_EXT;
        end
        else
        begin
            addr_h = triple;
        end
    end

    assign angle_next = (angle_reg == LAST) ? '0 : angle_reg + AW'(1);

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        issue.valid = 1'b0;
        issue.sel   = tpsh_pkg::SEL_H;
        rd_addr     = addr_h[AW-1:0];
        unique case (state_reg)
            tpsh_pkg::ST_FILL:
            begin
                if (fill_cnt_reg == LAST)
                begin
                    state_next = tpsh_pkg::ST_IDLE;
                end
            end
            tpsh_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = tpsh_pkg::ST_RD_H;
                end
            end
            tpsh_pkg::ST_RD_H:
            begin
                issue.valid = 1'b1;
                state_next  = tpsh_pkg::ST_RD_A;
            end
            tpsh_pkg::ST_RD_A:
            begin
                issue.valid = 1'b1;
                issue.sel   = tpsh_pkg::SEL_A;
                rd_addr     = angle_reg;
                state_next  = tpsh_pkg::ST_RD_B;
            end
            tpsh_pkg::ST_RD_B:
            begin
                issue.valid = 1'b1;
                issue.sel   = tpsh_pkg::SEL_B;
                rd_addr     = addr_b[AW-1:0];
                state_next  = tpsh_pkg::ST_RD_C;
            end
            tpsh_pkg::ST_RD_C:
            begin
                issue.valid = 1'b1;
                issue.sel   = tpsh_pkg::SEL_C;
                rd_addr     = addr_c[AW-1:0];
                state_next  = tpsh_pkg::ST_WAIT;
            end
            tpsh_pkg::ST_WAIT:
            begin
                if (res_tag.valid && res_tag.sel == tpsh_pkg::SEL_C)
                begin
                    state_next = tpsh_pkg::ST_DONE;
                end
            end
            tpsh_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = tpsh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpsh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpsh_pkg::ST_FILL;
            fill_cnt_reg  <= '0;
            angle_reg     <= '0;
            rd_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_tag_reg <= issue;
            if (wr_en)
            begin
                fill_cnt_reg <= fill_cnt_reg + AW'(1);
            end
            if (accept && s_tdata[0])
            begin
                angle_reg <= angle_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_tag.valid)
        begin
            unique case (res_tag.sel)
                tpsh_pkg::SEL_A: cmp_a_reg <= res_value;
                tpsh_pkg::SEL_B: cmp_b_reg <= res_value;
                tpsh_pkg::SEL_C: cmp_c_reg <= res_value;
                default:         cmp_a_reg <= cmp_a_reg;
            endcase
        end
        if (out_load)
        begin
            out_a_reg     <= cmp_a_reg;
            out_b_reg     <= cmp_b_reg;
            out_c_reg     <= cmp_c_reg;
            out_angle_reg <= angle_reg;
        end
    end

    tpsh_ram #(
        .WIDTH (tpsh_pkg::SINE_W),
        .DEPTH (tpsh_pkg::STEPS_PER_TURN)
    ) u_sine_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_cnt_reg),
        .wr_data (tpsh_pkg::SINE_TABLE[fill_cnt_reg]),
        .rd_en   (issue.valid),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tpsh_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_tag    (rd_tag_reg),
        .rd_data   (rd_data),
        .cfg       (cfg_reg),
        .res_tag   (res_tag),
        .res_value (res_value)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(64 - 3 * tpsh_pkg::CMP_W - AW){1'b0}}, out_angle_reg,
                       out_c_reg, out_b_reg, out_a_reg};

    `TPSH_ASSERT_SAME(a_angle_range, 1'b1, angle_reg <= LAST)
    `TPSH_ASSERT_SAME(a_no_read_in_fill, wr_en, !issue.valid)
    `TPSH_ASSERT_SAME(a_no_result_when_idle,
        state_reg == tpsh_pkg::ST_IDLE || state_reg == tpsh_pkg::ST_FILL, !res_tag.valid)
    `TPSH_ASSERT_NEXT(a_accept_starts_reads, accept, state_reg == tpsh_pkg::ST_RD_H)
    `TPSH_ASSERT_NEXT(a_load_shows_result, out_load, m_tvalid)

endmodule
